>>> sv/mrrb_pkg.sv
// Shared types and constants of the multi-reader ring buffer unit.
// No dependencies; imported by the top level and by the ring store.
`default_nettype none

package mrrb_pkg;

  // Default sizing of the ring and the reader table
  localparam int RING_DEPTH_DEF  = 1024;
  localparam int ELEM_WIDTH_DEF  = 32;
  localparam int NUM_READERS_DEF = 8;

  // Fixed port widths
  localparam int DATA_W  = 32;  // write_data, read_data
  localparam int IDX_W   = 3;   // reader_index, slot_given
  localparam int MASK_W  = 8;   // notify_mask
  localparam int CFG_W   = 11;  // buffer_length register field
  localparam int APB_W   = 32;  // pwdata, prdata
  localparam int PADDR_W = 3;   // one register, one word beyond it

  // Register indexes (word address = paddr[PADDR_W-1:2])
  localparam logic [PADDR_W-3:0] REG_BUFFER_LENGTH = 1'd0;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_JOIN   = 2'd2,
    CMD_RESIGN = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_READER  = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_NO_SLOT     = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> sv/mrrb_ring_store.sv
// Ring element store: one port, write or registered read each cycle.
// Uses mrrb_pkg for nothing but house constants; instantiated by the top level.
`default_nettype none

module mrrb_ring_store
  import mrrb_pkg::*;
#(
  parameter int DEPTH  = RING_DEPTH_DEF,
  parameter int WIDTH  = ELEM_WIDTH_DEF,
  parameter int ADDR_W = $clog2(RING_DEPTH_DEF)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/multi_reader_ring_buffer_unit.sv
// Top level of the multi-reader ring buffer: command decode, reader table,
// free-slot queue, length register and result stage. Uses mrrb_pkg and
// instantiates mrrb_ring_store.
//
// Channel   Direction  Handshake                     Payload
// --------  ---------  ----------------------------  ----------------------------------
// command   in         start & !busy                 command, write_data, reader_index,
//                                                    wants_notify
// result    out        done, one cycle, no stall     status, read_data, slot_given,
//                                                    reader_empty, notify_mask
// config    in/out     psel & penable & pwrite       paddr, pwdata, prdata (pready = 1)
//
// Cycles: one command per cycle; busy stays low. The result of a command
// accepted at edge N is on the result ports in the cycle after edge N, held
// in the result registers and the registered read port of the ring store.
// Reset (rst, synchronous) empties the reader table and the free queue, sets
// the length to RING_DEPTH and the write pointer to zero. The ring store is
// not cleared. The receiver cannot stall: each result shows for one cycle.
`default_nettype none

module multi_reader_ring_buffer_unit
  import mrrb_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int ELEM_WIDTH  = ELEM_WIDTH_DEF,
  parameter int NUM_READERS = NUM_READERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic [DATA_W-1:0]  write_data,
  input  wire logic [IDX_W-1:0]   reader_index,
  input  wire logic               wants_notify,
  // result channel
  output logic                    done,
  output logic [1:0]              status,
  output logic [DATA_W-1:0]       read_data,
  output logic [IDX_W-1:0]        slot_given,
  output logic                    reader_empty,
  output logic [MASK_W-1:0]       notify_mask,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]        prdata,
  output logic                    pready
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int LEN_W  = (PTR_W + 1 > CFG_W) ? PTR_W + 1 : CFG_W;
  localparam int SLOT_W = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int MASK_N = (NUM_READERS < MASK_W) ? NUM_READERS : MASK_W;

  localparam logic [LEN_W-1:0]       LEN_MAX   = LEN_W'(RING_DEPTH);
  localparam logic [LEN_W-1:0]       LEN_ONE   = LEN_W'(1);
  localparam logic [CNT_W-1:0]       NR_CNT    = CNT_W'(NUM_READERS);
  localparam logic [SLOT_W+IDX_W-1:0] IDX_LIMIT = (SLOT_W + IDX_W)'(NUM_READERS);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]  buffer_length;
  logic [PTR_W-1:0]  write_pointer;
  logic [PTR_W-1:0]  reader_position [NUM_READERS];
  logic              reader_valid    [NUM_READERS];
  logic              reader_notify   [NUM_READERS];
  logic [CNT_W-1:0]  slots_used;
  logic [SLOT_W-1:0] free_fifo       [NUM_READERS];
  logic [SLOT_W-1:0] free_head;
  logic [SLOT_W-1:0] free_tail;
  logic [CNT_W-1:0]  free_count;

  // result stage
  logic              res_get_ok;
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  res_given;
  logic              res_empty;
  logic [MASK_W-1:0] res_mask;

  // Advance a free-queue pointer, wrapping at NUM_READERS
  function automatic logic [SLOT_W-1:0] fifo_step(input logic [SLOT_W-1:0] p);
    logic [CNT_W-1:0] n;
    n = {1'b0, p} + CNT_W'(1);
    return (n >= NR_CNT) ? '0 : n[SLOT_W-1:0];
  endfunction

  // Advance a ring position, wrapping at the configured length
  function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] p,
                                                 input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = {{(LEN_W-PTR_W){1'b0}}, p} + LEN_ONE;
    return (n >= len) ? '0 : n[PTR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  cmd_t                     cmd;
  logic                     accept;
  logic [SLOT_W+IDX_W-1:0]  idx_wide;
  logic [SLOT_W-1:0]        slot;
  logic                     slot_ok;
  logic [PTR_W-1:0]         pos;
  logic [PTR_W-1:0]         pos_next;
  logic [PTR_W-1:0]         wp_next;
  logic                     get_ok;
  logic                     have_free;
  logic                     have_new;
  logic                     join_ok;
  logic [SLOT_W-1:0]        join_slot;
  logic [SLOT_W+IDX_W-1:0]  join_wide;
  logic [MASK_W-1:0]        put_mask;

  logic [1:0]               status_c;
  logic [IDX_W-1:0]         given_c;
  logic                     empty_c;
  logic [MASK_W-1:0]        mask_c;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign cmd    = cmd_t'(command);

  // Slots at or above NUM_READERS are rejected whatever the table holds
  assign idx_wide = {{SLOT_W{1'b0}}, reader_index};
  assign slot     = idx_wide[SLOT_W-1:0];
  assign slot_ok  = (idx_wide < IDX_LIMIT) & reader_valid[slot];
  assign pos      = reader_position[slot];
  assign pos_next = ring_step(pos, buffer_length);
  assign wp_next  = ring_step(write_pointer, buffer_length);
  assign get_ok   = slot_ok & (pos != write_pointer);

  // Freed slots go out oldest first; otherwise hand out the next unused one
  assign have_free = (free_count != '0);
  assign have_new  = (slots_used < NR_CNT);
  assign join_ok   = have_free | have_new;
  assign join_slot = have_free ? free_fifo[free_head] : slots_used[SLOT_W-1:0];
  assign join_wide = {{IDX_W{1'b0}}, join_slot};

  always_comb begin
    put_mask = '0;
    for (int i = 0; i < MASK_N; i++) begin
      put_mask[i] = reader_valid[i] & reader_notify[i];
    end
  end

  always_comb begin
    status_c = ST_OK;
    given_c  = '0;
    empty_c  = 1'b1;
    mask_c   = '0;
    case (cmd)
      CMD_PUT: begin
        empty_c = 1'b0;
        mask_c  = put_mask;
      end
      CMD_GET: begin
        if (!slot_ok) begin
          status_c = ST_BAD_READER;
        end else if (!get_ok) begin
          status_c = ST_EMPTY;
        end else begin
          // compare after the advance and wrap
          empty_c = (pos_next == write_pointer);
        end
      end
      CMD_JOIN: begin
        // a new reader starts at the write pointer, so it is always caught up
        if (join_ok) begin
          given_c = join_wide[IDX_W-1:0];
        end else begin
          status_c = ST_NO_SLOT;
        end
      end
      default: begin
        if (!slot_ok) begin
          status_c = ST_BAD_READER;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic             cfg_hit;
  logic             cfg_wr;
  logic [LEN_W-1:0] cfg_len;
  logic [LEN_W-1:0] cfg_len_clamped;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_BUFFER_LENGTH);
  assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;
  assign cfg_len = {{(LEN_W-CFG_W){1'b0}}, pwdata[CFG_W-1:0]};
  assign prdata  = cfg_hit ? {{(APB_W-LEN_W){1'b0}}, buffer_length} : '0;

  // zero acts as one, anything above the ring depth as the ring depth
  always_comb begin
    if (cfg_len == '0) begin
      cfg_len_clamped = LEN_ONE;
    end else if (cfg_len > LEN_MAX) begin
      cfg_len_clamped = LEN_MAX;
    end else begin
      cfg_len_clamped = cfg_len;
    end
  end

  // ---------------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= LEN_MAX;
      write_pointer <= '0;
      slots_used    <= '0;
      free_head     <= '0;
      free_tail     <= '0;
      free_count    <= '0;
      for (int i = 0; i < NUM_READERS; i++) begin
        reader_position[i] <= '0;
        reader_valid[i]    <= 1'b0;
        reader_notify[i]   <= 1'b0;
      end
    end else if (cfg_wr) begin
      buffer_length <= cfg_len_clamped;
      write_pointer <= '0;
    end else if (accept) begin
      case (cmd)
        CMD_PUT: begin
          write_pointer <= wp_next;
        end
        CMD_GET: begin
          if (get_ok) begin
            reader_position[slot] <= pos_next;
          end
        end
        CMD_JOIN: begin
          if (have_free) begin
            free_head  <= fifo_step(free_head);
            free_count <= free_count - CNT_W'(1);
          end else if (have_new) begin
            slots_used <= slots_used + CNT_W'(1);
          end
          if (join_ok) begin
            reader_position[join_slot] <= write_pointer;
            reader_valid[join_slot]    <= 1'b1;
            reader_notify[join_slot]   <= wants_notify;
          end
        end
        default: begin
          // a second resign of the same slot finds it invalid and is dropped
          if (slot_ok) begin
            if (free_count < NR_CNT) begin
              free_tail  <= fifo_step(free_tail);
              free_count <= free_count + CNT_W'(1);
            end
            reader_valid[slot]  <= 1'b0;
            reader_notify[slot] <= 1'b0;
          end
        end
      endcase
    end
  end

  // free queue entries carry no reset
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_RESIGN && slot_ok && free_count < NR_CNT) begin
      free_fifo[free_tail] <= slot;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring store: a put writes at the write pointer, a good get reads its entry
  // ---------------------------------------------------------------------------
  logic                       ring_we;
  logic                       ring_re;
  logic [PTR_W-1:0]           ring_addr;
  logic [DATA_W+ELEM_WIDTH-1:0] wdata_wide;
  logic [ELEM_WIDTH-1:0]      ring_q;
  logic [DATA_W+ELEM_WIDTH-1:0] rdata_wide;

  assign ring_we    = accept & (cmd == CMD_PUT);
  assign ring_re    = accept & (cmd == CMD_GET) & get_ok;
  assign ring_addr  = (cmd == CMD_PUT) ? write_pointer : pos;
  assign wdata_wide = {{ELEM_WIDTH{1'b0}}, write_data};

  mrrb_ring_store #(
    .DEPTH  (RING_DEPTH),
    .WIDTH  (ELEM_WIDTH),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .re    (ring_re),
    .addr  (ring_addr),
    .wdata (wdata_wide[ELEM_WIDTH-1:0]),
    .rdata (ring_q)
  );

  // ---------------------------------------------------------------------------
  // Result stage: hold each transfer for one cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_get_ok <= (cmd == CMD_GET) & get_ok;
      res_status <= status_c;
      res_given  <= given_c;
      res_empty  <= empty_c;
      res_mask   <= mask_c;
    end
  end

  assign rdata_wide   = {{DATA_W{1'b0}}, ring_q};
  assign read_data    = res_get_ok ? rdata_wide[DATA_W-1:0] : '0;
  assign status       = res_status;
  assign slot_given   = res_given;
  assign reader_empty = res_empty;
  assign notify_mask  = res_mask;

endmodule

`default_nettype wire

>>> tb/tb_multi_reader_ring_buffer_unit.sv
// Self-checking testbench for multi_reader_ring_buffer_unit: directed checks of the
// reader table, free-slot reuse and length changes, then long random command streams.
// Depends on mrrb_pkg and the RTL of the unit only.
`default_nettype none

module tb_multi_reader_ring_buffer_unit;
  import mrrb_pkg::*;

  localparam int NRD         = NUM_READERS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;
  // Word one of the register map holds nothing; writes there must be dropped
  localparam logic [PADDR_W-3:0] REG_UNMAPPED = 1'd1;

  // One result of the unit, as the predictor expects it
  typedef struct {
    status_t            status;
    logic [DATA_W-1:0]  read_data;
    logic [IDX_W-1:0]   slot_given;
    logic               reader_empty;
    logic [MASK_W-1:0]  notify_mask;
  } ring_reply_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         command;
  logic [DATA_W-1:0]  write_data;
  logic [IDX_W-1:0]   reader_index;
  logic               wants_notify;
  logic               done;
  logic [1:0]         status;
  logic [DATA_W-1:0]  read_data;
  logic [IDX_W-1:0]   slot_given;
  logic               reader_empty;
  logic [MASK_W-1:0]  notify_mask;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  multi_reader_ring_buffer_unit DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .command(command), .write_data(write_data),
    .reader_index(reader_index), .wants_notify(wants_notify),
    .done(done), .status(status), .read_data(read_data), .slot_given(slot_given),
    .reader_empty(reader_empty), .notify_mask(notify_mask),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the ring, the reader table and the
  // free-slot queue. ring_written marks entries that hold data, so the
  // stimulus never reads an entry the hardware leaves undefined.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] ring_copy    [RING_DEPTH_DEF];
  bit                ring_written [RING_DEPTH_DEF];
  int unsigned       ring_len;
  int unsigned       wr_ptr;
  int unsigned       rd_pos       [NRD];
  bit                rd_valid     [NRD];
  bit                rd_notify    [NRD];
  int unsigned       slots_taken;
  int unsigned       free_slots   [NRD];
  int unsigned       free_rd;
  int unsigned       free_wr;
  int unsigned       free_cnt;

  ring_reply_t replies_due [$];
  ring_reply_t reply_want;
  int          error_count = 0;
  int          cycle_count = 0;

  // Free-running clock, period 2
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if the stimulus or the results stall
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               replies_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (error_count < PRINT_LIMIT)
      $display("cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    error_count++;
  endtask

  // Result checker: every done pulse is one transfer; compare it against the
  // oldest prediction. Outputs are sampled at the edge that ends their cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result, status", DATA_W'(status), '0);
      end else begin
        reply_want = replies_due.pop_front();
        if (status !== reply_want.status)
          report_mismatch("status", DATA_W'(status), DATA_W'(reply_want.status));
        if (read_data !== reply_want.read_data)
          report_mismatch("read_data", read_data, reply_want.read_data);
        if (slot_given !== reply_want.slot_given)
          report_mismatch("slot_given", DATA_W'(slot_given),
                          DATA_W'(reply_want.slot_given));
        if (reader_empty !== reply_want.reader_empty)
          report_mismatch("reader_empty", DATA_W'(reader_empty),
                          DATA_W'(reply_want.reader_empty));
        if (notify_mask !== reply_want.notify_mask)
          report_mismatch("notify_mask", DATA_W'(notify_mask),
                          DATA_W'(reply_want.notify_mask));
      end
    end
  end

  task automatic model_reset();
    ring_written = '{default: 1'b0};
    rd_pos       = '{default: 0};
    rd_valid     = '{default: 1'b0};
    rd_notify    = '{default: 1'b0};
    ring_len     = RING_DEPTH_DEF;
    wr_ptr       = 0;
    slots_taken  = 0;
    free_rd      = 0;
    free_wr      = 0;
    free_cnt     = 0;
  endtask

  // Apply one accepted command to the predictor state and return its result
  function automatic ring_reply_t predict_command(cmd_t cmd, logic [DATA_W-1:0] data,
                                                  logic [IDX_W-1:0] idx, logic notify);
    ring_reply_t r;
    int unsigned p;
    int unsigned s;
    bit          got;
    r.status       = ST_OK;
    r.read_data    = '0;
    r.slot_given   = '0;
    r.reader_empty = 1'b0;
    r.notify_mask  = '0;
    s              = 0;
    got            = 1'b1;
    case (cmd)
      CMD_PUT: begin
        ring_copy[wr_ptr]    = data;
        ring_written[wr_ptr] = 1'b1;
        wr_ptr++;
        if (wr_ptr >= ring_len) wr_ptr = 0;
        for (int i = 0; i < NRD; i++)
          if (rd_valid[i] && rd_notify[i]) r.notify_mask[i] = 1'b1;
      end
      CMD_GET: begin
        if (!rd_valid[idx]) begin
          r.status = ST_BAD_READER;
        end else if (rd_pos[idx] == wr_ptr) begin
          r.status = ST_EMPTY;
        end else begin
          // read, advance, wrap, and only then compare with the write pointer
          p           = rd_pos[idx];
          r.read_data = ring_copy[p];
          p++;
          if (p >= ring_len) p = 0;
          rd_pos[idx] = p;
        end
        r.reader_empty = !rd_valid[idx] || (rd_pos[idx] == wr_ptr);
      end
      CMD_JOIN: begin
        if (free_cnt > 0) begin
          s       = free_slots[free_rd];
          free_rd = (free_rd + 1) % NRD;
          free_cnt--;
        end else if (slots_taken < NRD) begin
          s = slots_taken;
          slots_taken++;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          rd_pos[s]      = wr_ptr;
          rd_valid[s]    = 1'b1;
          rd_notify[s]   = notify;
          r.slot_given   = IDX_W'(s);
          r.reader_empty = (rd_pos[s] == wr_ptr);
        end else begin
          r.status       = ST_NO_SLOT;
          r.reader_empty = 1'b1;
        end
      end
      default: begin
        if (!rd_valid[idx]) begin
          r.status = ST_BAD_READER;
        end else begin
          if (free_cnt < NRD) begin
            free_slots[free_wr] = 32'(idx);
            free_wr             = (free_wr + 1) % NRD;
            free_cnt++;
          end
          rd_valid[idx]  = 1'b0;
          rd_notify[idx] = 1'b0;
        end
        r.reader_empty = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Drive one command and hold it until the unit takes it. Call at a clock
  // edge; start stays high on return so back-to-back commands need no gap.
  task automatic send_command(input cmd_t cmd, input logic [DATA_W-1:0] data,
                              input logic [IDX_W-1:0] idx, input logic notify);
    start        <= 1'b1;
    command      <= cmd;
    write_data   <= data;
    reader_index <= idx;
    wants_notify <= notify;
    do @(posedge clk); while (busy);
    replies_due.insert(replies_due.size(), predict_command(cmd, data, idx, notify));
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random idle bursts on the sender side
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(7) == 0) hold_off($urandom_range(1, 13));
  endtask

  // Stop sending and wait for every predicted result, plus the read latency
  task automatic wait_results_drained();
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready
  task automatic apb_write(input logic [PADDR_W-3:0] reg_sel, input logic [APB_W-1:0] value);
    int unsigned len;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_BUFFER_LENGTH) begin
      // out-of-range lengths clamp to 1 and to the ring depth
      len = value & 32'h7FF;
      if (len < 1) len = 1;
      if (len > RING_DEPTH_DEF) len = RING_DEPTH_DEF;
      ring_len = len;
      wr_ptr   = 0;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Empty table: gets and resigns hit invalid slots, a put notifies nobody
  task automatic test_empty_table();
    send_command(CMD_GET, '0, 3'd0, 1'b0);
    send_command(CMD_RESIGN, '0, 3'd7, 1'b1);
    send_command(CMD_PUT, 32'hFFFF_FFFF, 3'd5, 1'b1);
  endtask

  // Fill all slots with alternating notification, overflow once, then put
  task automatic test_fill_table();
    for (int s = 0; s < NRD; s++) send_command(CMD_JOIN, 32'hA5A5_5A5A, 3'd0, s[0]);
    send_command(CMD_JOIN, '0, 3'd3, 1'b1);
    send_command(CMD_PUT, 32'h0000_0000, 3'd2, 1'b0);
  endtask

  // Read the one pending element, then hit the caught-up reader
  task automatic test_reader_gets();
    send_command(CMD_GET, '0, 3'd0, 1'b0);
    send_command(CMD_GET, 32'hFFFF_FFFF, 3'd0, 1'b1);
  endtask

  // Free two slots, resign one twice, rejoin in the order freed
  task automatic test_resign_reuse();
    send_command(CMD_RESIGN, '0, 3'd3, 1'b0);
    send_command(CMD_RESIGN, '0, 3'd3, 1'b0);
    send_command(CMD_RESIGN, '0, 3'd5, 1'b0);
    send_command(CMD_JOIN, '0, 3'd6, 1'b1);
    send_command(CMD_JOIN, '0, 3'd1, 1'b0);
  endtask

  // Shrink the ring below a reader's position: the reader reads its entry,
  // then wraps to zero. A write to the unmapped word must change nothing.
  task automatic test_length_change();
    wait_results_drained();
    apb_write(REG_BUFFER_LENGTH, 32'd8);
    send_command(CMD_RESIGN, '0, 3'd2, 1'b0);
    send_command(CMD_JOIN, '0, 3'd2, 1'b0);
    repeat (3) send_command(CMD_PUT, $urandom, IDX_W'($urandom_range(NRD - 1)), 1'b0);
    repeat (2) send_command(CMD_GET, '0, 3'd2, 1'b0);
    wait_results_drained();
    apb_write(REG_BUFFER_LENGTH, 32'd2);
    apb_write(REG_UNMAPPED, 32'd5);
    send_command(CMD_GET, '0, 3'd2, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random test: phases with different ring lengths, mostly well-formed
  // traffic against live readers plus a share of invalid slots and overflow.
  // ---------------------------------------------------------------------------
  task automatic issue_random_command();
    int unsigned pick;
    int unsigned live [$];
    cmd_t        cmd;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    for (int s = 0; s < NRD; s++)
      if (rd_valid[s]) live.insert(live.size(), s);
    idx = IDX_W'($urandom_range(NRD - 1));
    if (live.size() != 0 && $urandom_range(7) != 0)
      idx = IDX_W'(live[$urandom_range(live.size() - 1)]);
    if (pick < 35)      cmd = CMD_PUT;
    else if (pick < 75) cmd = CMD_GET;
    else if (pick < 87) cmd = CMD_JOIN;
    else                cmd = CMD_RESIGN;
    // keep a few readers alive so gets reach the data path
    if (cmd == CMD_RESIGN && live.size() < 3 && $urandom_range(3) != 0) cmd = CMD_JOIN;
    if (cmd == CMD_JOIN && live.size() == NRD && $urandom_range(3) != 0) cmd = CMD_GET;
    // never read an entry that was never written
    if (cmd == CMD_GET && rd_valid[idx] && rd_pos[idx] != wr_ptr && !ring_written[rd_pos[idx]])
      cmd = CMD_PUT;
    send_command(cmd, $urandom, idx, 1'($urandom_range(1)));
  endtask

  task automatic test_random_traffic();
    int unsigned len_sel [10] = '{5, 1, 2, 3, 0, 16, 2047, 7, 1024, 32'hFFFF_F804};
    int unsigned len;
    bit          idle_on;
    for (int ph = 0; ph < 13; ph++) begin
      len = (ph < $size(len_sel)) ? len_sel[ph] : $urandom_range(4, 40);
      wait_results_drained();
      apb_write(REG_BUFFER_LENGTH, len);
      // idle in most phases, none in every third and none at the end
      idle_on = (ph % 3 != 2) && (ph < 11);
      for (int n = 0; n < 155; n++) begin
        maybe_idle(idle_on);
        issue_random_command();
        // hold the sender once until every outstanding result is back
        if (ph == 4 && n == 70) wait_results_drained();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    command      <= CMD_PUT;
    write_data   <= '0;
    reader_index <= '0;
    wants_notify <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_reader_gets();
    test_resign_reuse();
    test_length_change();
    test_random_traffic();

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
